// ===== hw/rtl/char_cell_dirty_tracker_unit_macros.svh =====
// Assertion macros for the tracker RTL.
`ifndef CHAR_CELL_DIRTY_TRACKER_UNIT_MACROS_SVH
`define CHAR_CELL_DIRTY_TRACKER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/cct_pkg.sv =====
package cct_pkg;

	// Default geometry and cell width.
	localparam int COLS_DEF      = 32;
	localparam int ROWS_DEF      = 16;
	localparam int CELL_BITS_DEF = 8;

	// Fixed field widths of the transactions.
	localparam int MODE_W = 3;
	localparam int COL_W  = 5;
	localparam int ROW_W  = 4;
	localparam int VAL_W  = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE   = 3'd0,
		MODE_READ    = 3'd1,
		MODE_CUR_ON  = 3'd2,
		MODE_CUR_OFF = 3'd3,
		MODE_MOVE    = 3'd4,
		MODE_RESTART = 3'd5,
		MODE_NEXT    = 3'd6,
		MODE_CLEAR   = 3'd7
	} mode_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_FETCH,
		ST_UPDATE,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_wr;
		logic accept;
		logic tgt_cursor;
		logic tgt_cmd;
		logic cell_wr;
		logic mark_wr;
		logic unmark_wr;
		logic cursor_set;
		logic cursor_clr;
		logic cursor_move;
		logic scan_restart;
		logic scan_start;
		logic scan_sel;
		logic scan_step;
		logic clear_all;
		logic out_load;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		mode_t mode;
		logic  clr_last;
		logic  cmd_on;
		logic  cursor_on_scr;
		logic  cursor_en;
		logic  cell_diff;
		logic  scan_hit;
		logic  scan_last;
	} sts_t;

endpackage

// ===== hw/rtl/cct_if.sv =====
interface cct_cmd_if import cct_pkg::*;;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [COL_W-1:0]  col;
	logic [ROW_W-1:0]  row;
	logic [VAL_W-1:0]  cell_value;

	modport source (output valid, mode, col, row, cell_value, input ready);
	modport sink (input valid, mode, col, row, cell_value, output ready);
endinterface

interface cct_rsp_if import cct_pkg::*;;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] read_value;
	logic             found;
	logic [COL_W-1:0] dirty_col;
	logic [ROW_W-1:0] dirty_row;

	modport source (output valid, read_value, found, dirty_col, dirty_row, input ready);
	modport sink (input valid, read_value, found, dirty_col, dirty_row, output ready);
endinterface

// ===== hw/rtl/cct_ctrl.sv =====
module cct_ctrl import cct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output ctl_t ctl,
	input  sts_t sts
);

	state_t state_q, state_d;
	logic   pend_q, pend_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		ctl     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				ctl.accept = in_valid;
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				pend_d = 1'b0;
				unique case (sts.mode) inside
					MODE_WRITE, MODE_READ: begin
						state_d = sts.cmd_on ? ST_FETCH : ST_DONE;
					end
					MODE_CUR_ON, MODE_CUR_OFF: begin
						ctl.cursor_set = (sts.mode == MODE_CUR_ON);
						ctl.cursor_clr = (sts.mode == MODE_CUR_OFF);
						ctl.tgt_cursor = 1'b1;
						state_d = sts.cursor_on_scr ? ST_MARK_RD : ST_DONE;
					end
					MODE_MOVE: begin
						ctl.cursor_move = 1'b1;
						state_d = ST_DONE;
						if (sts.cursor_en) begin
							if (sts.cursor_on_scr) begin
								// Old cell first, new cell after it.
								ctl.tgt_cursor = 1'b1;
								pend_d = 1'b1;
								state_d = ST_MARK_RD;
							end else if (sts.cmd_on) begin
								state_d = ST_MARK_RD;
							end
						end
					end
					MODE_RESTART: begin
						ctl.scan_restart = 1'b1;
						state_d = ST_DONE;
					end
					MODE_NEXT: begin
						ctl.scan_start = 1'b1;
						state_d = ST_SCAN_RD;
					end
					MODE_CLEAR: begin
						ctl.clear_all = 1'b1;
						state_d = ST_DONE;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_FETCH: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (sts.mode == MODE_WRITE) begin
					ctl.cell_wr = sts.cell_diff;
					ctl.mark_wr = sts.cell_diff;
				end else begin
					ctl.unmark_wr = 1'b1;
				end
				state_d = ST_DONE;
			end
			ST_MARK_RD: begin
				state_d = ST_MARK_WR;
			end
			ST_MARK_WR: begin
				ctl.mark_wr = 1'b1;
				state_d = ST_DONE;
				if (pend_q) begin
					pend_d = 1'b0;
					ctl.tgt_cmd = 1'b1;
					state_d = sts.cmd_on ? ST_MARK_RD : ST_DONE;
				end
			end
			ST_SCAN_RD: begin
				ctl.scan_sel = 1'b1;
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				ctl.scan_step = 1'b1;
				state_d = (sts.scan_hit || sts.scan_last) ? ST_DONE : ST_SCAN_RD;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/cct_dp.sv =====
module cct_dp import cct_pkg::*; #(
	parameter int COLS      = COLS_DEF,
	parameter int ROWS      = ROWS_DEF,
	parameter int CELL_BITS = CELL_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	output sts_t              sts,
	input  logic [MODE_W-1:0] mode,
	input  logic [COL_W-1:0]  col,
	input  logic [ROW_W-1:0]  row,
	input  logic [VAL_W-1:0]  cell_value,
	output logic [VAL_W-1:0]  read_value,
	output logic              found,
	output logic [COL_W-1:0]  dirty_col,
	output logic [ROW_W-1:0]  dirty_row
);

	localparam int CELLS = COLS * ROWS;
	localparam int CW    = $clog2(COLS);
	localparam int RW    = $clog2(ROWS);
	localparam int AW    = $clog2(CELLS);

	// Stores
	logic [CELL_BITS-1:0] cell_mem [CELLS];
	logic [COLS-1:0]      dirty_mem [ROWS];
	logic [ROWS-1:0]      row_vld_q;

	// Latched command and current target cell
	mode_t            mode_q;
	logic [COL_W-1:0] col_q, tgt_col_q, cursor_col_q;
	logic [ROW_W-1:0] row_q, tgt_row_q, cursor_row_q;
	logic [VAL_W-1:0] val_q;
	logic             cursor_en_q;

	logic [AW-1:0]        clr_cnt_q;
	logic [CELL_BITS-1:0] cell_rd_q;
	logic [COLS-1:0]      dirty_rd_q;
	logic                 dirty_rd_vld_q;

	logic [RW-1:0] scan_row_q, walk_row_q;
	logic [CW-1:0] scan_col_q;
	logic          first_q;

	logic [VAL_W-1:0] rd_val_q;
	logic             found_q;
	logic [CW-1:0]    fcol_q;
	logic [RW-1:0]    frow_q;

	logic [VAL_W-1:0] out_rd_q;
	logic             out_found_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;

	logic [CW-1:0]        tgt_col_idx, hit_col;
	logic [RW-1:0]        tgt_row_idx, dirty_rd_addr;
	logic [AW-1:0]        tgt_idx, cell_wr_addr;
	logic [CELL_BITS-1:0] cell_wr_data;
	logic [COLS-1:0]      tgt_bit, row_cur, row_new, scan_bits;
	logic                 hit;

	assign tgt_col_idx = CW'(tgt_col_q);
	assign tgt_row_idx = RW'(tgt_row_q);
	assign tgt_idx     = AW'(int'(tgt_row_idx) * COLS + int'(tgt_col_idx));

	assign cell_wr_addr  = ctl.clr_wr ? clr_cnt_q : tgt_idx;
	assign cell_wr_data  = ctl.clr_wr ? '0 : CELL_BITS'(val_q);
	assign dirty_rd_addr = ctl.scan_sel ? walk_row_q : tgt_row_idx;

	always_comb begin
		tgt_bit = '0;
		tgt_bit[tgt_col_idx] = 1'b1;
	end

	// A row that has not been written since the last clear reads as clean.
	assign row_cur = dirty_rd_vld_q ? dirty_rd_q : '0;
	assign row_new = ctl.unmark_wr ? (row_cur & ~tgt_bit) : (row_cur | tgt_bit);

	// Lowest dirty column in the fetched row, from the scan column on the first row.
	always_comb begin
		hit     = 1'b0;
		hit_col = '0;
		for (int j = 0; j < COLS; j++) begin
			scan_bits[j] = row_cur[j] && (!first_q || (CW'(j) >= scan_col_q));
		end
		for (int j = COLS - 1; j >= 0; j--) begin
			if (scan_bits[j]) begin
				hit     = 1'b1;
				hit_col = CW'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clr_wr || ctl.cell_wr) begin
			cell_mem[cell_wr_addr] <= cell_wr_data;
		end
		cell_rd_q <= cell_mem[tgt_idx];
	end

	always_ff @(posedge clk) begin
		if (ctl.mark_wr || ctl.unmark_wr) begin
			dirty_mem[tgt_row_idx] <= row_new;
		end
		dirty_rd_q     <= dirty_mem[dirty_rd_addr];
		dirty_rd_vld_q <= row_vld_q[dirty_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q    <= '0;
			clr_cnt_q    <= '0;
			cursor_en_q  <= 1'b0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			scan_row_q   <= '0;
			scan_col_q   <= '0;
		end else begin
			if (ctl.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (ctl.clear_all) begin
				row_vld_q <= '0;
			end else if (ctl.mark_wr || ctl.unmark_wr) begin
				row_vld_q[tgt_row_idx] <= 1'b1;
			end
			if (ctl.cursor_set) begin
				cursor_en_q <= 1'b1;
			end else if (ctl.cursor_clr) begin
				cursor_en_q <= 1'b0;
			end
			if (ctl.cursor_move) begin
				cursor_col_q <= col_q;
				cursor_row_q <= row_q;
			end
			if (ctl.scan_restart) begin
				scan_row_q <= '0;
				scan_col_q <= '0;
			end else if (ctl.scan_step && hit) begin
				scan_row_q <= walk_row_q;
				scan_col_q <= hit_col;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			mode_q    <= mode_t'(mode);
			col_q     <= col;
			row_q     <= row;
			val_q     <= cell_value;
			tgt_col_q <= col;
			tgt_row_q <= row;
			rd_val_q  <= '0;
			found_q   <= 1'b0;
			fcol_q    <= '0;
			frow_q    <= '0;
		end else if (ctl.tgt_cursor) begin
			tgt_col_q <= cursor_col_q;
			tgt_row_q <= cursor_row_q;
		end else if (ctl.tgt_cmd) begin
			tgt_col_q <= col_q;
			tgt_row_q <= row_q;
		end
		if (ctl.unmark_wr) begin
			rd_val_q <= VAL_W'(cell_rd_q);
		end
		if (ctl.scan_start) begin
			walk_row_q <= scan_row_q;
			first_q    <= 1'b1;
		end else if (ctl.scan_step) begin
			if (hit) begin
				found_q <= 1'b1;
				fcol_q  <= hit_col;
				frow_q  <= walk_row_q;
			end else begin
				walk_row_q <= walk_row_q + RW'(1);
				first_q    <= 1'b0;
			end
		end
		if (ctl.out_load) begin
			out_rd_q    <= rd_val_q;
			out_found_q <= found_q;
			out_col_q   <= COL_W'(fcol_q);
			out_row_q   <= ROW_W'(frow_q);
		end
	end

	assign sts.mode          = mode_q;
	assign sts.clr_last      = (clr_cnt_q == AW'(CELLS - 1));
	assign sts.cmd_on        = (9'(col_q) < 9'(COLS)) && (9'(row_q) < 9'(ROWS));
	assign sts.cursor_on_scr = (9'(cursor_col_q) < 9'(COLS)) && (9'(cursor_row_q) < 9'(ROWS));
	assign sts.cursor_en     = cursor_en_q;
	assign sts.cell_diff     = (cell_rd_q != CELL_BITS'(val_q));
	assign sts.scan_hit      = hit;
	assign sts.scan_last     = (walk_row_q == RW'(ROWS - 1));

	assign read_value = out_rd_q;
	assign found      = out_found_q;
	assign dirty_col  = out_col_q;
	assign dirty_row  = out_row_q;

endmodule

// ===== hw/rtl/char_cell_dirty_tracker_unit.sv =====
// Channel   Direction  Fields                                   Accepted when
// cmd       in         mode, col, row, cell_value               cmd.valid && cmd.ready
// rsp       out        read_value, found, dirty_col, dirty_row  rsp.valid && rsp.ready
//
// After reset the cell store is swept to zero, one cell per cycle, through all COLS*ROWS cells
// (512 by default), and cmd.ready stays low for that time. One transaction is worked at a time.
// A next-dirty scan walks the rows from the scan position, with a dirty-row read and a priority
// check for each row walked, and stops at the first hit or the last row. A stalled result waits
// in the output register; the next command may still be taken, and its result waits until the
// first leaves.
`include "char_cell_dirty_tracker_unit_macros.svh"

module char_cell_dirty_tracker_unit import cct_pkg::*; #(
	parameter int COLS      = COLS_DEF,
	parameter int ROWS      = ROWS_DEF,
	parameter int CELL_BITS = CELL_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cct_cmd_if.sink   cmd,
	cct_rsp_if.source rsp
);

	// The controller sequences each transaction; the datapath holds the stores,
	// the cursor, the scan position and the result registers.
	ctl_t ctl;
	sts_t sts;

	// Handshake terms used by the checks at the end.
	logic cmd_taken;
	logic rsp_hit;
	logic hit_on_screen;

	cct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	cct_dp #(
		.COLS      (COLS),
		.ROWS      (ROWS),
		.CELL_BITS (CELL_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.mode       (cmd.mode),
		.col        (cmd.col),
		.row        (cmd.row),
		.cell_value (cmd.cell_value),
		.read_value (rsp.read_value),
		.found      (rsp.found),
		.dirty_col  (rsp.dirty_col),
		.dirty_row  (rsp.dirty_row)
	);

	assign cmd_taken     = cmd.valid && cmd.ready;
	assign rsp_hit       = rsp.valid && rsp.found;
	assign hit_on_screen = (int'(rsp.dirty_row) < ROWS) && (int'(rsp.dirty_col) < COLS);

	// No command may enter while the store is still being swept.
	`ASSERT_IMPLIES(a_no_cmd_in_sweep, clk, arst_n, ctl.clr_wr, !cmd.ready, "command during sweep")
	// A command is worked alone: ready drops right after acceptance.
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, cmd_taken, !cmd.ready, "second command taken")
	// A found cell lies on the screen.
	`ASSERT_IMPLIES(a_found_on_screen, clk, arst_n, rsp_hit, hit_on_screen, "found cell off screen")
	// Scan results never carry a read value.
	`ASSERT_IMPLIES(a_found_no_value, clk, arst_n, rsp_hit, rsp.read_value == '0, "read value on scan")

endmodule
